>>> sv/crt_pkg.sv
// crt_pkg: types and codes of the retransmission table.
// Used by every module of the block.
`timescale 1ns / 1ps
package crt_pkg;
	localparam logic [1:0] ACT_OPEN   = 2'd0;
	localparam logic [1:0] ACT_CANCEL = 2'd1;
	localparam logic [1:0] ACT_TICK   = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [2:0] EV_SENT     = 3'd0;
	localparam logic [2:0] EV_RESENT   = 3'd1;
	localparam logic [2:0] EV_GAVE_UP  = 3'd2;
	localparam logic [2:0] EV_NO_FREE  = 3'd3;
	localparam logic [2:0] EV_CANCELED = 3'd4;
	localparam logic [2:0] EV_NOTFOUND = 3'd5;
	localparam logic [2:0] EV_IDLE     = 3'd6;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_MAX  = 1'b1;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] trans_id;
		logic [63:0] peer_addr_high;
		logic [63:0] peer_addr_low;
		logic [15:0] peer_port;
		logic        confirmable;
	} req_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [2:0]  slot;
		logic [15:0] out_id;
		logic [63:0] out_addr_high;
		logic [63:0] out_addr_low;
		logic [15:0] out_port;
		logic        last;
	} res_t;
endpackage

>>> sv/crt_if.sv
// crt_req_if, crt_res_if: valid/ready channels for request and result words.
// Depends on no other file.
`timescale 1ns / 1ps
interface crt_req_if;
	logic valid;
	logic ready;
	logic [1:0]  action;
	logic [15:0] trans_id;
	logic [63:0] peer_addr_high;
	logic [63:0] peer_addr_low;
	logic [15:0] peer_port;
	logic        confirmable;
	modport source (output valid, action, trans_id, peer_addr_high, peer_addr_low,
		peer_port, confirmable, input ready);
	modport sink (input valid, action, trans_id, peer_addr_high, peer_addr_low,
		peer_port, confirmable, output ready);
endinterface

interface crt_res_if;
	logic valid;
	logic ready;
	logic [2:0]  event_res;
	logic [2:0]  slot;
	logic [15:0] out_id;
	logic [63:0] out_addr_high;
	logic [63:0] out_addr_low;
	logic [15:0] out_port;
	logic        last;
	modport source (output valid, event_res, slot, out_id, out_addr_high, out_addr_low,
		out_port, last, input ready);
	modport sink (input valid, event_res, slot, out_id, out_addr_high, out_addr_low,
		out_port, last, output ready);
endinterface

>>> sv/confirmable_retransmit_table.sv
// confirmable_retransmit_table: top level of the retransmission table.
// Depends on crt_pkg, crt_if, crt_front, crt_back, crt_outbuf.
//
//  channel | dir | word
//  req     | in  | action, trans_id, peer address, port, confirmable
//  res     | out | event_res, slot, transaction fields, last
//  cfg     | in  | cfg_we, cfg_index, cfg_data (16 bit)
//
// The sequencer visits one slot per cycle; a resend word is emitted during the
// visit of its slot, while a give-up word takes a state of its own. The front
// register and the output buffer are registered. Reset clears valid bits and
// sets the registers to 2 and 4.
// The front register takes the next word while the back part works; a stalled
// result word holds the sequencer at its current slot.
`timescale 1ns / 1ps
module confirmable_retransmit_table #(
	parameter int SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	crt_req_if.sink     req,
	crt_res_if.source   res
);
	crt_pkg::req_t in_req, q_req;
	crt_pkg::res_t r;
	logic q_valid, q_ready, rv, rr;
	logic tick_end;

	assign in_req = {req.action, req.trans_id, req.peer_addr_high, req.peer_addr_low,
		req.peer_port, req.confirmable};

	crt_front u_front (.clk, .arst_n, .in_valid(req.valid), .in_ready(req.ready),
		.in_req, .q_valid, .q_ready, .q_req);

	crt_back #(.SLOTS(SLOTS)) u_back (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.q_valid, .q_ready, .q_req, .out_valid(rv), .out_ready(rr), .out_res(r),
		.tick_end);

	// Back part clears last on tick resend and give-up words and on a sent
	// word a give-up follows; such a word waits for the next word or tick end.
	crt_pkg::res_t bres;

	crt_outbuf u_buf (.clk, .arst_n, .in_valid(rv), .in_ready(rr), .in_res(r),
		.flush(tick_end), .out_valid(res.valid), .out_ready(res.ready), .out_res(bres));

	assign {res.event_res, res.slot, res.out_id, res.out_addr_high, res.out_addr_low,
		res.out_port, res.last} = bres;

	a_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.event_res <= crt_pkg::EV_IDLE))
		else $error("result code out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> res.valid)
		else $error("result word dropped under stall");
endmodule

>>> sv/crt_front.sv
// crt_front: request register; drops unused action codes.
// Depends on crt_pkg.
`timescale 1ns / 1ps
module crt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  crt_pkg::req_t  in_req,
	output logic           q_valid,
	input  logic           q_ready,
	output crt_pkg::req_t  q_req
);
	logic          full_q;
	crt_pkg::req_t req_q;

	assign in_ready = !full_q || q_ready;
	assign q_valid  = full_q;
	assign q_req    = req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_ready) begin
			full_q <= in_valid && (in_req.action != crt_pkg::ACT_UNUSED);
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_q <= in_req;
		end
	end
endmodule

>>> sv/crt_back.sv
// crt_back: slot table and sequencer, one slot per cycle, one result word per step;
// a stalled result word holds the sequencer at its slot. Depends on crt_pkg.
`timescale 1ns / 1ps
module crt_back #(
	parameter int SLOTS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [15:0]    cfg_data,
	input  logic           q_valid,
	output logic           q_ready,
	input  crt_pkg::req_t  q_req,
	output logic           out_valid,
	input  logic           out_ready,
	output crt_pkg::res_t  out_res,
	output logic           tick_end
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_OPEN, ST_GIVE, ST_TICK, ST_FIN}
		state_t;

	state_t          state_q;
	logic [SW:0]     idx_q;
	crt_pkg::req_t   req_q;
	logic            any_q;
	logic [15:0]     base_q;
	logic [3:0]      max_q;

	logic [SLOTS-1:0] valid_q;
	logic [15:0]  id_q    [SLOTS];
	logic [63:0]  ah_q    [SLOTS];
	logic [63:0]  al_q    [SLOTS];
	logic [15:0]  port_q  [SLOTS];
	logic [3:0]   retry_q [SLOTS];
	logic [31:0]  cnt_q   [SLOTS];

	crt_pkg::res_t res_q;
	logic          ov_q;
	logic [SW-1:0] cur;
	logic          done;
	logic          can_emit;

	assign cur      = idx_q[SW-1:0];
	assign done     = (idx_q == (SW+1)'(SLOTS));
	assign can_emit = !ov_q || out_ready;
	assign q_ready  = (state_q == ST_IDLE);
	assign out_valid = ov_q;
	assign out_res   = res_q;
	// final tick word has left the output register: the buffer may mark it last
	assign tick_end  = (state_q == ST_FIN) && any_q && !ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 16'd2;
			max_q  <= 4'd4;
		end else if (cfg_we) begin
			if (cfg_index == crt_pkg::REG_BASE) base_q <= cfg_data;
			else max_q <= cfg_data[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic ov_d;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			ov_q    <= 1'b0;
			idx_q   <= '0;
			any_q   <= 1'b0;
		end else begin
			ov_d = ov_q && !out_ready;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						req_q   <= q_req;
						idx_q   <= '0;
						any_q   <= 1'b0;
						state_q <= (q_req.action == crt_pkg::ACT_TICK) ? ST_TICK : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (done) begin
						if (can_emit) begin
							ov_d = 1'b1;
							res_q <= {(req_q.action == crt_pkg::ACT_OPEN) ? crt_pkg::EV_NO_FREE
								: crt_pkg::EV_NOTFOUND, 3'd0, req_q.trans_id,
								req_q.peer_addr_high, req_q.peer_addr_low, req_q.peer_port, 1'b1};
							state_q <= ST_IDLE;
						end
					end else if (req_q.action == crt_pkg::ACT_OPEN) begin
						if (!valid_q[cur]) begin
							id_q[cur]    <= req_q.trans_id;
							ah_q[cur]    <= req_q.peer_addr_high;
							al_q[cur]    <= req_q.peer_addr_low;
							port_q[cur]  <= req_q.peer_port;
							retry_q[cur] <= 4'd0;
							state_q      <= ST_OPEN;
						end else idx_q <= idx_q + 1'b1;
					end else begin
						if (valid_q[cur] && id_q[cur] == req_q.trans_id) begin
							if (can_emit) begin
								valid_q[cur] <= 1'b0;
								ov_d = 1'b1;
								res_q <= {crt_pkg::EV_CANCELED, 3'(cur), id_q[cur], ah_q[cur],
									al_q[cur], port_q[cur], 1'b1};
								state_q <= ST_IDLE;
							end
						end else idx_q <= idx_q + 1'b1;
					end
				end
				ST_OPEN: begin
					if (can_emit) begin
						ov_d = 1'b1;
						if (req_q.confirmable && max_q != 4'd0) begin
							valid_q[cur] <= 1'b1;
							cnt_q[cur]   <= {16'd0, base_q};
							state_q      <= ST_IDLE;
							res_q <= {crt_pkg::EV_SENT, 3'(cur), id_q[cur], ah_q[cur],
								al_q[cur], port_q[cur], 1'b1};
						end else begin
							valid_q[cur] <= 1'b0;
							state_q <= req_q.confirmable ? ST_GIVE : ST_IDLE;
							res_q <= {crt_pkg::EV_SENT, 3'(cur), id_q[cur], ah_q[cur],
								al_q[cur], port_q[cur], !req_q.confirmable};
						end
					end
				end
				ST_TICK: begin
					if (done) begin
						state_q <= ST_FIN;
					end else if (!valid_q[cur]) begin
						idx_q <= idx_q + 1'b1;
					end else if (cnt_q[cur] > 32'd1) begin
						cnt_q[cur] <= cnt_q[cur] - 32'd1;
						idx_q <= idx_q + 1'b1;
					end else if (can_emit) begin
						// Resend; the output buffer decides on last later.
						any_q <= 1'b1;
						ov_d = 1'b1;
						retry_q[cur] <= retry_q[cur] + 4'd1;
						res_q <= {crt_pkg::EV_RESENT, 3'(cur), id_q[cur], ah_q[cur],
							al_q[cur], port_q[cur], 1'b0};
						if ((retry_q[cur] + 4'd1) < max_q) begin
							cnt_q[cur] <= 32'(base_q) << (retry_q[cur] + 4'd1);
							idx_q <= idx_q + 1'b1;
						end else begin
							cnt_q[cur]   <= 32'd0;
							valid_q[cur] <= 1'b0;
							state_q <= ST_GIVE;
						end
					end
				end
				ST_GIVE: begin
					if (can_emit) begin
						ov_d = 1'b1;
						res_q <= {crt_pkg::EV_GAVE_UP, 3'(cur), id_q[cur], ah_q[cur],
							al_q[cur], port_q[cur], req_q.action != crt_pkg::ACT_TICK};
						if (req_q.action == crt_pkg::ACT_TICK) begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_TICK;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FIN: begin
					// no expiry: an idle word; else wait for the final word to leave
					if (!any_q) begin
						if (can_emit) begin
							ov_d = 1'b1;
							res_q <= {crt_pkg::EV_IDLE, 3'd0, 16'd0, 64'd0, 64'd0, 16'd0, 1'b1};
							state_q <= ST_IDLE;
						end
					end else if (!ov_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			ov_q <= ov_d;
		end
	end
endmodule

>>> sv/crt_outbuf.sv
// crt_outbuf: two-word lookahead so the final tick result can carry last.
// Depends on crt_pkg.
`timescale 1ns / 1ps
module crt_outbuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  crt_pkg::res_t  in_res,
	input  logic           flush,
	output logic           out_valid,
	input  logic           out_ready,
	output crt_pkg::res_t  out_res
);
	logic          full_q;
	logic          nfull_q;
	crt_pkg::res_t r_q;
	crt_pkg::res_t n_q;
	crt_pkg::res_t r_fin;
	crt_pkg::res_t n_fin;
	logic          pop;
	logic          push;

	// A head word without last waits until a word follows it or flush marks it final.
	assign out_valid = full_q && (r_q.last || nfull_q);
	assign out_res   = r_q;
	assign in_ready  = !nfull_q;
	assign pop       = out_valid && out_ready;
	assign push      = in_valid && in_ready;

	// flush marks the newest word held
	always_comb begin
		r_fin = r_q;
		r_fin.last = r_q.last || (flush && !nfull_q);
		n_fin = n_q;
		n_fin.last = n_q.last || (flush && nfull_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= 1'b0;
			nfull_q <= 1'b0;
		end else if (pop) begin
			if (nfull_q) nfull_q <= 1'b0;
			else if (!push) full_q <= 1'b0;
		end else if (push) begin
			if (full_q) nfull_q <= 1'b1;
			else full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (nfull_q) r_q <= n_fin;
			else if (push) r_q <= in_res;
		end else if (push) begin
			if (full_q) n_q <= in_res;
			else r_q <= in_res;
		end else begin
			r_q <= r_fin;
			n_q <= n_fin;
		end
	end
endmodule

>>> dv/crt_table_checker.sv
// crt_table_checker: watches the request and result channels of the
// retransmission table, predicts every result word and compares. Depends on crt_pkg, crt_if.
`timescale 1ns / 1ps
module crt_table_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	crt_req_if          req,
	crt_res_if          res,
	output int          fail_count,
	output int          pending,
	output int          word_count,
	output int          resend_count,
	output int          give_up_count
);
	localparam int SLOTS = 8;

	logic [15:0] base_ticks;
	logic [3:0]  retry_limit;
	logic        busy [SLOTS];
	logic [15:0] tx_id [SLOTS];
	logic [63:0] tx_ah [SLOTS];
	logic [63:0] tx_al [SLOTS];
	logic [15:0] tx_port [SLOTS];
	logic [3:0]  retries [SLOTS];
	logic [31:0] ticks_left [SLOTS];
	crt_pkg::res_t expected_words [$];

	function automatic crt_pkg::res_t slot_word(logic [2:0] ev, int s);
		crt_pkg::res_t w;
		w = '{ev, 3'(s), tx_id[s], tx_ah[s], tx_al[s], tx_port[s], 1'b0};
		return w;
	endfunction

	// rearm a sent slot or release it, flagging a give-up for confirmable words
	task automatic rearm_or_release(int s, logic con);
		if (con && retries[s] < retry_limit) begin
			ticks_left[s] = 32'(base_ticks) << retries[s];
			busy[s] = 1'b1;
		end else begin
			if (con) expected_words.push_back(slot_word(crt_pkg::EV_GAVE_UP, s));
			busy[s] = 1'b0;
		end
	endtask

	task automatic predict_table(crt_pkg::req_t r);
		int s;
		int first;
		first = expected_words.size();
		case (r.action)
			crt_pkg::ACT_OPEN: begin
				for (s = 0; s < SLOTS; s++) if (!busy[s]) break;
				if (s == SLOTS) begin
					expected_words.push_back('{crt_pkg::EV_NO_FREE, 3'd0, r.trans_id,
						r.peer_addr_high, r.peer_addr_low, r.peer_port, 1'b0});
				end else begin
					tx_id[s] = r.trans_id;
					tx_ah[s] = r.peer_addr_high;
					tx_al[s] = r.peer_addr_low;
					tx_port[s] = r.peer_port;
					retries[s] = '0;
					expected_words.push_back(slot_word(crt_pkg::EV_SENT, s));
					rearm_or_release(s, r.confirmable);
				end
			end
			crt_pkg::ACT_CANCEL: begin
				for (s = 0; s < SLOTS; s++) if (busy[s] && tx_id[s] == r.trans_id) break;
				if (s == SLOTS) begin
					expected_words.push_back('{crt_pkg::EV_NOTFOUND, 3'd0, r.trans_id,
						r.peer_addr_high, r.peer_addr_low, r.peer_port, 1'b0});
				end else begin
					busy[s] = 1'b0;
					expected_words.push_back(slot_word(crt_pkg::EV_CANCELED, s));
				end
			end
			crt_pkg::ACT_TICK: begin
				for (s = 0; s < SLOTS; s++) begin
					if (!busy[s]) continue;
					if (ticks_left[s] > 1) begin
						ticks_left[s]--;
						continue;
					end
					ticks_left[s] = '0;
					retries[s] = retries[s] + 4'd1;
					expected_words.push_back(slot_word(crt_pkg::EV_RESENT, s));
					rearm_or_release(s, 1'b1);
				end
				if (expected_words.size() == first)
					expected_words.push_back('{crt_pkg::EV_IDLE, 3'd0, 16'd0, 64'd0, 64'd0,
						16'd0, 1'b0});
			end
			default: ;
		endcase
		if (expected_words.size() > first)
			expected_words[expected_words.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		crt_pkg::res_t got;
		crt_pkg::res_t want;
		if (!arst_n) begin
			base_ticks <= 16'd2;
			retry_limit <= 4'd4;
			for (int s = 0; s < SLOTS; s++) busy[s] <= 1'b0;
			expected_words.delete();
			fail_count <= 0;
			word_count <= 0;
			resend_count <= 0;
			give_up_count <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == crt_pkg::REG_BASE) base_ticks <= cfg_data;
				else retry_limit <= cfg_data[3:0];
			end
			// result side first: a word cannot be caused by one accepted at the same edge
			if (res.valid && res.ready) begin
				got = '{res.event_res, res.slot, res.out_id, res.out_addr_high,
					res.out_addr_low, res.out_port, res.last};
				word_count <= word_count + 1;
				if (got.event_res == crt_pkg::EV_RESENT) resend_count <= resend_count + 1;
				if (got.event_res == crt_pkg::EV_GAVE_UP) give_up_count <= give_up_count + 1;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						$display("%0t: result mismatch: expected %h, actual %h",
							$time, want, got);
						if (got.event_res !== want.event_res)
							$display("  event_res expected %0d actual %0d",
								want.event_res, got.event_res);
						if (got.slot !== want.slot)
							$display("  slot expected %0d actual %0d", want.slot, got.slot);
						if (got.last !== want.last)
							$display("  last expected %0d actual %0d", want.last, got.last);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (req.valid && req.ready)
				predict_table('{req.action, req.trans_id, req.peer_addr_high,
					req.peer_addr_low, req.peer_port, req.confirmable});
		end
	end

	assign pending = expected_words.size();
endmodule

>>> dv/confirmable_retransmit_table_test.sv
// confirmable_retransmit_table_test: stimulus and verdict for the table.
// Depends on crt_pkg, crt_if, crt_table_checker and the block itself.
`timescale 1ns / 1ps
module confirmable_retransmit_table_test;
	localparam int  LIMIT = 400000;
	// worst item: a full sequencer pass plus a give-up word per slot, each word possibly stalled
	localparam int  DRAIN = 200;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	int          fail_count;
	int          pending;
	int          word_count;
	int          resend_count;
	int          give_up_count;
	int          cycle = 0;
	int          sent_words;
	bit          hold_off;
	bit          stall_on;
	logic [15:0] recent_ids [$];

	crt_req_if req ();
	crt_res_if res ();

	confirmable_retransmit_table #(.SLOTS(8)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req.sink), .res(res.source)
	);

	crt_table_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req), .res(res), .fail_count(fail_count),
		.pending(pending), .word_count(word_count), .resend_count(resend_count),
		.give_up_count(give_up_count)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// watchdog: the run never outlives the cycle limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle, pending);
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random stalls in patches, clean runs, and one long hold-off on demand
	initial begin
		int hold;
		int mode;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				res.ready <= 1'b0;
				for (hold = 0; hold < 300; hold++) @(negedge clk);
				hold_off = 1'b0;
				res.ready <= 1'b1;
			end else begin
				if ($urandom_range(0, 31) == 0) stall_on = ~stall_on;
				mode = $urandom_range(0, 3);
				res.ready <= stall_on ? (mode != 0) : 1'b1;
			end
		end
	end

	// offer one word and hold it until the block takes it
	task automatic offer(logic [1:0] act, logic [15:0] id, logic con);
		req.valid <= 1'b1;
		req.action <= act;
		req.trans_id <= id;
		req.peer_addr_high <= {$urandom, $urandom};
		req.peer_addr_low <= {$urandom, $urandom};
		req.peer_port <= 16'($urandom);
		req.confirmable <= con;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		sent_words++;
	endtask

	task automatic pause_sender();
		req.valid <= 1'b0;
		repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	// wait until every predicted word has come, then let a trailing item settle
	task automatic wait_quiet();
		req.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// random mix: mostly opens and ticks, cancels aimed at live ids,
	// an odd unused action and raw noise ids
	task automatic random_phase(int count);
		int k;
		int pick;
		logic [15:0] id;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				id = 16'($urandom);
				recent_ids.push_back(id);
				if (recent_ids.size() > 16) void'(recent_ids.pop_front());
				offer(crt_pkg::ACT_OPEN, id, $urandom_range(0, 5) != 0);
			end else if (pick < 55) begin
				id = (recent_ids.size() != 0 && $urandom_range(0, 3) != 0) ?
					recent_ids[$urandom_range(0, recent_ids.size() - 1)] : 16'($urandom);
				offer(crt_pkg::ACT_CANCEL, id, 1'($urandom));
			end else if (pick < 97) begin
				offer(crt_pkg::ACT_TICK, 16'($urandom), 1'($urandom));
			end else begin
				offer(crt_pkg::ACT_UNUSED, 16'($urandom), 1'($urandom));
			end
			if ($urandom_range(0, 7) == 0) pause_sender();
		end
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = crt_pkg::REG_BASE;
		cfg_data = '0;
		sent_words = 0;
		hold_off = 1'b0;
		stall_on = 1'b0;
		req.valid = 1'b0;
		req.action = crt_pkg::ACT_OPEN;
		req.trans_id = '0;
		req.peer_addr_high = '0;
		req.peer_addr_low = '0;
		req.peer_port = '0;
		req.confirmable = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, default registers: idle tick, miss, extremes, fill to full
		offer(crt_pkg::ACT_TICK, 16'hFFFF, 1'b1);
		offer(crt_pkg::ACT_CANCEL, 16'h1234, 1'b0);
		offer(crt_pkg::ACT_OPEN, 16'h0000, 1'b0);
		offer(crt_pkg::ACT_OPEN, 16'hFFFF, 1'b1);
		req.valid <= 1'b1;
		req.action <= crt_pkg::ACT_OPEN;
		req.trans_id <= 16'hFFFF;
		req.peer_addr_high <= '1;
		req.peer_addr_low <= '1;
		req.peer_port <= '1;
		req.confirmable <= 1'b1;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		sent_words++;
		for (k = 0; k < 7; k++) offer(crt_pkg::ACT_OPEN, 16'(k + 16'h100), 1'b1);
		offer(crt_pkg::ACT_CANCEL, 16'hFFFF, 1'b0);
		offer(crt_pkg::ACT_UNUSED, 16'h0101, 1'b1);
		for (k = 0; k < 6; k++) offer(crt_pkg::ACT_TICK, 16'h0, 1'b0);
		wait_quiet();

		// max retransmit zero: confirmable open gives up at once
		write_reg(crt_pkg::REG_MAX, 16'd0);
		write_reg(crt_pkg::REG_BASE, 16'd0);
		offer(crt_pkg::ACT_OPEN, 16'h00AA, 1'b1);
		offer(crt_pkg::ACT_OPEN, 16'h00AB, 1'b0);
		offer(crt_pkg::ACT_TICK, 16'h0, 1'b0);
		wait_quiet();

		// zero base, limit 15: each tick expires every slot
		write_reg(crt_pkg::REG_MAX, 16'd15);
		random_phase(40);
		wait_quiet();

		// large base, long hold-off while the sender keeps offering
		write_reg(crt_pkg::REG_BASE, 16'hFFFF);
		write_reg(crt_pkg::REG_MAX, 16'd3);
		hold_off = 1'b1;
		random_phase(30);
		wait_quiet();

		// small base and middling limits, the bulk of the random items
		write_reg(crt_pkg::REG_BASE, 16'd1);
		write_reg(crt_pkg::REG_MAX, 16'd2);
		random_phase(50);
		wait_quiet();
		write_reg(crt_pkg::REG_BASE, 16'd3);
		write_reg(crt_pkg::REG_MAX, 16'd5);
		random_phase(50);
		wait_quiet();

		$display("covered %0d request words, %0d result words (%0d resends, %0d give-ups)",
			sent_words, word_count, resend_count, give_up_count);
		$display("over base timeouts 0, 1, 3, 2 and 65535 and retry limits 0 to 15");
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
